@@ src/itp_pkg.sv @@
// Shared character codes and digit decoding for the integer text parser.
package itp_pkg;

    localparam int DIGIT_BITS = 7;

    typedef logic [7:0]            char_t;
    typedef logic [DIGIT_BITS-1:0] digit_t;

    localparam char_t CH_SPACE = 8'h20;
    localparam char_t CH_TAB   = 8'h09;
    localparam char_t CH_MINUS = 8'h2D;
    localparam char_t CH_PLUS  = 8'h2B;
    localparam char_t CH_0     = 8'h30;
    localparam char_t CH_9     = 8'h39;
    localparam char_t CH_LO_A  = 8'h61;
    localparam char_t CH_LO_Z  = 8'h7A;
    localparam char_t CH_UP_A  = 8'h41;
    localparam char_t CH_UP_Z  = 8'h5A;
    localparam char_t CH_LO_X  = 8'h78;
    localparam char_t CH_UP_X  = 8'h58;

    localparam logic [5:0] BASE_AUTO  = 6'd0;
    localparam logic [5:0] BASE_OCT   = 6'd8;
    localparam logic [5:0] BASE_DEC   = 6'd10;
    localparam logic [5:0] BASE_HEX   = 6'd16;
    localparam digit_t     DIGIT_NONE = 7'h7F;

    // Value of a digit or letter, or DIGIT_NONE for any other character.
    function automatic digit_t digit_of(input char_t c);
        char_t diff;
        begin
            diff = 8'd0;
            if (c inside {[CH_0 : CH_9]})
            begin
                diff = c - CH_0;
                digit_of = diff[DIGIT_BITS-1:0];
            end
            else if (c inside {[CH_LO_A : CH_LO_Z]})
            begin
                diff = c - CH_LO_A + 8'd10;
                digit_of = diff[DIGIT_BITS-1:0];
            end
            else if (c inside {[CH_UP_A : CH_UP_Z]})
            begin
                diff = c - CH_UP_A + 8'd10;
                digit_of = diff[DIGIT_BITS-1:0];
            end
            else
            begin
                digit_of = DIGIT_NONE;
            end
        end
    endfunction

endpackage

@@ src/integer_text_parser.sv @@
// Streaming signed-integer parser that takes one character per request.
//
// The parser accepts one character request in every clock cycle in which
// char_stall is low, and turns a string into a signed 64-bit value, the
// number of characters consumed and a wrap flag. A request carrying
// string_start begins a new string. Leading spaces and tabs are skipped, one
// optional sign is taken, and with base_select at zero a leading 0 selects
// octal and 0x or 0X selects hexadecimal. The first character that is not a
// digit of the active base ends the parse and produces exactly one result;
// later characters are dropped until the next string_start. A character
// waits in the input register while the parse stage works on it, and the
// result is then loaded into the output register, from which it can be
// taken. The parse stage holds one 64-by-6 multiply-add per character,
// which is what sets the one-character-per-cycle rate. The output register
// decouples the two sides: a new character is still taken while a result
// waits, and result_stall only holds the input side back when the output
// register is full and the input register already holds a character.
// The user must write base_select through the cfg port only while no
// string is in flight; the block itself does not enforce it. The port is
// always ready.
module integer_text_parser #(
    parameter int COUNT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  base_select,

    input  logic        char_valid,
    output logic        char_stall,
    input  logic [7:0]  char_code,
    input  logic        string_start,

    output logic        result_valid,
    input  logic        result_stall,
    output logic [63:0] parsed_value,
    output logic [15:0] consumed_count,
    output logic        overflow_flag
);

    // Parse phases.
    localparam logic [2:0] PH_DONE  = 3'd0;
    localparam logic [2:0] PH_SPACE = 3'd1;
    localparam logic [2:0] PH_BASE  = 3'd2;
    localparam logic [2:0] PH_ZERO  = 3'd3;
    localparam logic [2:0] PH_DIGIT = 3'd4;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Configuration register.
    logic [5:0] base_sel_reg;

    // Input register.
    logic                s1_valid_reg;
    itp_pkg::char_t      s1_char_reg;
    logic                s1_start_reg;

    // Parse state.
    logic [2:0]            phase_reg,   phase_next;
    logic                  neg_reg,     neg_next;
    logic [5:0]            base_reg,    base_next;
    logic [63:0]           acc_reg,     acc_next;
    logic [COUNT_BITS-1:0] count_reg,   count_next;
    logic                  wrap_reg,    wrap_next;

    // Output register.
    logic        out_valid_reg;
    logic [63:0] out_value_reg;
    logic [15:0] out_count_reg;
    logic        out_wrap_reg;

    logic             emit;
    logic             bump;
    logic             cont;
    itp_pkg::digit_t  digit;
    logic [69:0]      mac;
    logic [31:0]      count_wide;
    logic             out_free;
    logic             s1_fire;

    assign cfg_ready  = 1'b1;
    assign out_free   = !out_valid_reg || !result_stall;
    assign s1_fire    = s1_valid_reg && out_free;
    assign char_stall = s1_valid_reg && !out_free;

    assign digit = itp_pkg::digit_of(s1_char_reg);

    // One character of parse work. A new string clears the state first, then
    // the phases fall through in order until one of them consumes the
    // character or the parse ends.
    always_comb
    begin
        phase_next = s1_start_reg ? PH_SPACE : phase_reg;
        neg_next   = s1_start_reg ? 1'b0     : neg_reg;
        base_next  = s1_start_reg ? 6'd0     : base_reg;
        acc_next   = s1_start_reg ? 64'd0    : acc_reg;
        count_next = s1_start_reg ? '0       : count_reg;
        wrap_next  = s1_start_reg ? 1'b0     : wrap_reg;
        emit       = 1'b0;
        bump       = 1'b0;
        cont       = (phase_next != PH_DONE);
        mac        = 70'(acc_next) * 70'(base_next) + 70'(digit);

        if (cont && phase_next == PH_SPACE)
        begin
            if (s1_char_reg == itp_pkg::CH_SPACE || s1_char_reg == itp_pkg::CH_TAB)
            begin
                bump = 1'b1;
                cont = 1'b0;
            end
            else
            begin
                phase_next = PH_BASE;
                if (s1_char_reg == itp_pkg::CH_MINUS || s1_char_reg == itp_pkg::CH_PLUS)
                begin
                    neg_next = (s1_char_reg == itp_pkg::CH_MINUS);
                    bump     = 1'b1;
                    cont     = 1'b0;
                end
            end
        end

        if (cont && phase_next == PH_BASE)
        begin
            if (base_sel_reg == itp_pkg::BASE_AUTO)
            begin
                base_next = itp_pkg::BASE_DEC;
                if (s1_char_reg == itp_pkg::CH_0)
                begin
                    base_next  = itp_pkg::BASE_OCT;
                    phase_next = PH_ZERO;
                    bump       = 1'b1;
                    cont       = 1'b0;
                end
            end
            else
            begin
                base_next = base_sel_reg;
            end
            if (cont)
            begin
                phase_next = PH_DIGIT;
            end
        end

        if (cont && phase_next == PH_ZERO)
        begin
            phase_next = PH_DIGIT;
            if (s1_char_reg == itp_pkg::CH_LO_X || s1_char_reg == itp_pkg::CH_UP_X)
            begin
                base_next = itp_pkg::BASE_HEX;
                bump      = 1'b1;
                cont      = 1'b0;
            end
        end

        // Base is final here, so the multiply-add is recomputed with it.
        mac = 70'(acc_next) * 70'(base_next) + 70'(digit);

        if (cont)
        begin
            if (digit < {1'b0, base_next})
            begin
                wrap_next = wrap_next | (|mac[69:64]);
                acc_next  = mac[63:0];
                bump      = 1'b1;
            end
            else
            begin
                emit       = 1'b1;
                phase_next = PH_DONE;
            end
        end

        if (bump && count_next != COUNT_MAX)
        begin
            count_next = count_next + 1'b1;
        end
    end

    assign count_wide = 32'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_sel_reg <= itp_pkg::BASE_DEC;
        end
        else if (cfg_valid && cfg_ready)
        begin
            base_sel_reg <= base_select;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!char_stall)
        begin
            s1_valid_reg <= char_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && !char_stall)
        begin
            s1_char_reg  <= char_code;
            s1_start_reg <= string_start;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_DONE;
            neg_reg   <= 1'b0;
            base_reg  <= 6'd0;
            acc_reg   <= 64'd0;
            count_reg <= '0;
            wrap_reg  <= 1'b0;
        end
        else if (s1_fire)
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            base_reg  <= base_next;
            acc_reg   <= acc_next;
            count_reg <= count_next;
            wrap_reg  <= wrap_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && emit)
        begin
            out_value_reg <= neg_next ? (64'd0 - acc_next) : acc_next;
            out_count_reg <= count_wide[15:0];
            out_wrap_reg  <= wrap_next;
        end
    end

    assign result_valid   = out_valid_reg;
    assign parsed_value   = out_value_reg;
    assign consumed_count = out_count_reg;
    assign overflow_flag  = out_wrap_reg;

endmodule

@@ src/itp_checker.sv @@
// Port-level checks for the integer text parser, bound to the top level.
module itp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic        char_valid,
    input logic        char_stall,
    input logic        result_valid,
    input logic        result_stall,
    input logic [63:0] parsed_value,
    input logic [15:0] consumed_count,
    input logic        overflow_flag
);

    // A held result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(parsed_value)
            && $stable(consumed_count) && $stable(overflow_flag))
        else $error("held result changed");

    // A fresh result follows an accepted character.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(char_valid && !char_stall, 2))
        else $error("result without a terminating character");

    // With nothing consumed there were no digits, so the value is zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && consumed_count == 16'd0 |-> parsed_value == 64'd0 && !overflow_flag)
        else $error("nonzero value with empty count");

    // The configuration port never pushes back.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind integer_text_parser itp_checker u_itp_checker (.*);

@@ tb/sv/tb_integer_text_parser.sv @@
// Self-checking testbench for the streaming integer text parser.
module tb_integer_text_parser;

    // The count width that the block is built with here, and the point at
    // which its character count stops climbing.
    localparam int COUNT_BITS = 16;
    localparam int COUNT_MAX  = (1 << COUNT_BITS) - 1;

    // A result passes the input register and then the output register after its
    // terminating character. Before a base change the bench also waits out
    // PIPE_SETTLE, so that a trailing character that causes no result has left.
    localparam int PIPE_SETTLE = 8;
    localparam int END_DRAIN   = 10;

    // The limit lies far above the length of a correct run, even if every
    // character ended a string and each result met the longest receiver stall.
    localparam int CYCLE_LIMIT = 1000000;

    localparam int RANDOM_CHARS = 700;
    localparam int REPORT_MAX   = 10;

    localparam itp_pkg::char_t CHR_NUL = 8'h00;

    // Phases of the parse, as the predictor tracks them.
    typedef enum logic [2:0] {
        PARSE_IDLE,
        PARSE_LEAD,
        PARSE_SIGN,
        PARSE_ZERO,
        PARSE_DIGITS
    } parse_phase_t;

    typedef struct packed {
        logic [63:0] value;
        logic [15:0] count;
        logic        ovf;
    } parse_result_t;

    // A row of the directed table either sends one character request or
    // changes the base between strings.
    typedef enum logic {
        ROW_CHAR,
        ROW_BASE
    } row_kind_t;

    typedef struct {
        row_kind_t      kind;
        itp_pkg::char_t ch;
        logic           st;
        bit             given;
        parse_result_t  result;
    } stim_row_t;

    logic           clk;
    logic           rst_n;
    logic           cfg_valid;
    logic           cfg_ready;
    logic [5:0]     base_select;
    logic           char_valid;
    logic           char_stall;
    itp_pkg::char_t char_code;
    logic           string_start;
    logic           result_valid;
    logic           result_stall;
    logic [63:0]    parsed_value;
    logic [15:0]    consumed_count;
    logic           overflow_flag;

    integer_text_parser #(
        .COUNT_BITS(COUNT_BITS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .base_select   (base_select),
        .char_valid    (char_valid),
        .char_stall    (char_stall),
        .char_code     (char_code),
        .string_start  (string_start),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .parsed_value  (parsed_value),
        .consumed_count(consumed_count),
        .overflow_flag (overflow_flag)
    );

    // Predictor state: a private copy of the base register and of the
    // parser's own registers.
    logic [5:0]    base_reg;
    parse_phase_t  parse_phase;
    bit            neg_seen;
    int            act_base;
    logic [63:0]   acc;
    int            char_count;
    bit            wrap_seen;

    // Results still owed by the block, oldest first.
    parse_result_t result_q[$];
    stim_row_t     dir_rows[$];

    int  errors;
    int  cycle_count;
    int  burst_left;
    int  live_chars;
    bit  pending_start;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The cycle counter is the only watchdog: every wait in the bench that can
    // hang is on a handshake or on the result queue, so a hung block ends here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, result_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Value of a digit or letter, or 255 for anything else.
    function automatic int char_value(input itp_pkg::char_t c);
        if (c >= itp_pkg::CH_0 && c <= itp_pkg::CH_9)
            return int'(c - itp_pkg::CH_0);
        if (c >= itp_pkg::CH_LO_A && c <= itp_pkg::CH_LO_Z)
            return int'(c - itp_pkg::CH_LO_A) + 10;
        if (c >= itp_pkg::CH_UP_A && c <= itp_pkg::CH_UP_Z)
            return int'(c - itp_pkg::CH_UP_A) + 10;
        return 255;
    endfunction

    function automatic void bump_count();
        if (char_count < COUNT_MAX)
            char_count++;
    endfunction

    function automatic void clear_parse();
        parse_phase = PARSE_IDLE;
        neg_seen    = 1'b0;
        act_base    = 0;
        acc         = 64'd0;
        char_count  = 0;
        wrap_seen   = 1'b0;
    endfunction

    // Steps the parser by one accepted character request. Returns 1 when the
    // character ends the parse, with the result the block must then produce.
    // The phases fall through into each other within one character, just as
    // the block does: a character that is neither space nor sign is looked
    // at again as a base prefix and then as a digit.
    function automatic bit predict_char(input itp_pkg::char_t c, input logic s,
                                        output parse_result_t r);
        int           d;
        logic [127:0] prod;
        r = '0;
        if (s)
        begin
            clear_parse();
            parse_phase = PARSE_LEAD;
        end
        if (parse_phase == PARSE_IDLE)
            return 1'b0;

        if (parse_phase == PARSE_LEAD)
        begin
            if (c == itp_pkg::CH_SPACE || c == itp_pkg::CH_TAB)
            begin
                bump_count();
                return 1'b0;
            end
            parse_phase = PARSE_SIGN;
            if (c == itp_pkg::CH_MINUS || c == itp_pkg::CH_PLUS)
            begin
                neg_seen = (c == itp_pkg::CH_MINUS);
                bump_count();
                return 1'b0;
            end
        end

        if (parse_phase == PARSE_SIGN)
        begin
            if (base_reg == itp_pkg::BASE_AUTO)
            begin
                act_base = int'(itp_pkg::BASE_DEC);
                if (c == itp_pkg::CH_0)
                begin
                    act_base    = int'(itp_pkg::BASE_OCT);
                    parse_phase = PARSE_ZERO;
                    bump_count();
                    return 1'b0;
                end
            end
            else
            begin
                act_base = int'(base_reg);
            end
            parse_phase = PARSE_DIGITS;
        end

        if (parse_phase == PARSE_ZERO)
        begin
            parse_phase = PARSE_DIGITS;
            if (c == itp_pkg::CH_LO_X || c == itp_pkg::CH_UP_X)
            begin
                act_base = int'(itp_pkg::BASE_HEX);
                bump_count();
                return 1'b0;
            end
        end

        d = char_value(c);
        if (d < act_base)
        begin
            prod = {64'd0, acc} * 128'(act_base) + 128'(d);
            if (prod[127:64] != 0)
                wrap_seen = 1'b1;
            acc = prod[63:0];
            bump_count();
            return 1'b0;
        end

        r.value     = neg_seen ? (64'd0 - acc) : acc;
        r.count     = 16'(char_count);
        r.ovf       = wrap_seen;
        parse_phase = PARSE_IDLE;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Sends one character request. The sender works in bursts of random
    // length; between bursts valid drops for a random gap, and about a third
    // of the bursts follow the previous one with no gap at all. The task is
    // entered and left at a falling edge, so a valid that stays high into
    // the next request is never lowered in between. When given is set, the
    // result comes from the directed table instead of the predictor.
    task automatic send_char(input itp_pkg::char_t c, input logic s, input bit given,
                             input parse_result_t given_r);
        parse_result_t r;
        bit            got;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 2) != 0)
            begin
                char_valid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        char_valid   <= 1'b1;
        char_code    <= c;
        string_start <= s;
        do
            @(posedge clk);
        while (char_stall);
        live_chars++;
        got = predict_char(c, s, r);
        if (given)
            result_q.push_back(given_r);
        else if (got)
            result_q.push_back(r);
        @(negedge clk);
    endtask

    task automatic send_plain(input itp_pkg::char_t c, input logic s);
        send_char(c, s, 1'b0, '0);
    endtask

    // A character inside a generated string: the first one opens the string,
    // and now and then a later one restarts it so that a parse is dropped.
    task automatic send_text(input itp_pkg::char_t c);
        send_plain(c, pending_start || $urandom_range(0, 59) == 0);
        pending_start = 1'b0;
    endtask

    // Changes the base only with the block idle: no result owed and the
    // pipeline given time to empty of characters that cause no result.
    task automatic write_base(input logic [5:0] b);
        char_valid <= 1'b0;
        while (result_q.size() != 0)
            @(negedge clk);
        repeat (PIPE_SETTLE) @(negedge clk);
        cfg_valid   <= 1'b1;
        base_select <= b;
        do
            @(posedge clk);
        while (!cfg_ready);
        base_reg = b;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic itp_pkg::char_t digit_char(input int v);
        if (v < 10)
            return itp_pkg::char_t'(int'(itp_pkg::CH_0) + v);
        if ($urandom_range(0, 1) == 0)
            return itp_pkg::char_t'(int'(itp_pkg::CH_LO_A) + v - 10);
        return itp_pkg::char_t'(int'(itp_pkg::CH_UP_A) + v - 10);
    endfunction

    // One random string. Most are well formed: blanks, a sign, a base
    // prefix in automatic mode, digits of the active base and a terminator,
    // then a few characters that the block must ignore. About one in six is
    // plain noise with random start marks. Long digit runs reach the wrap.
    task automatic send_string();
        int eb;
        int n_digits;
        int v;
        int prefix;
        if ($urandom_range(0, 5) == 0)
        begin
            repeat ($urandom_range(1, 8))
                send_plain(itp_pkg::char_t'($urandom_range(0, 255)),
                           $urandom_range(0, 3) == 0);
            return;
        end

        pending_start = 1'b1;
        repeat ($urandom_range(0, 3))
            send_text($urandom_range(0, 1) ? itp_pkg::CH_SPACE : itp_pkg::CH_TAB);
        case ($urandom_range(0, 2))
            0: send_text(itp_pkg::CH_MINUS);
            1: send_text(itp_pkg::CH_PLUS);
            default: ;
        endcase

        prefix = 0;
        if (base_reg == itp_pkg::BASE_AUTO)
        begin
            prefix = $urandom_range(0, 2);
            eb = int'(itp_pkg::BASE_DEC);
            if (prefix != 0)
            begin
                send_text(itp_pkg::CH_0);
                eb = int'(itp_pkg::BASE_OCT);
            end
            if (prefix == 2)
            begin
                send_text($urandom_range(0, 1) ? itp_pkg::CH_LO_X : itp_pkg::CH_UP_X);
                eb = int'(itp_pkg::BASE_HEX);
            end
        end
        else
        begin
            eb = (base_reg > 36) ? 36 : int'(base_reg);
        end

        n_digits = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 24) : $urandom_range(0, 6);
        for (int i = 0; i < n_digits; i++)
        begin
            v = (eb > 1) ? $urandom_range(0, eb - 1) : 0;
            // A leading zero in automatic mode would switch to octal.
            if (base_reg == itp_pkg::BASE_AUTO && prefix == 0 && i == 0 && v == 0)
                v = 1;
            send_text(digit_char(v));
        end

        case ($urandom_range(0, 3))
            0: send_text(CHR_NUL);
            1: send_text(itp_pkg::char_t'($urandom_range(0, 255)));
            2: send_text($urandom_range(0, 1) ? ".": itp_pkg::CH_SPACE);
            default: send_text((eb < 36) ? digit_char(eb) : CHR_NUL);
        endcase

        repeat ($urandom_range(0, 2))
            send_plain(itp_pkg::char_t'($urandom_range(0, 255)), 1'b0);
    endtask

    // Directed table builders.
    task automatic row_char(input itp_pkg::char_t ch, input logic st);
        dir_rows.push_back('{ROW_CHAR, ch, st, 1'b0, '0});
    endtask

    task automatic row_check(input itp_pkg::char_t ch, input logic st,
                             input logic [63:0] v, input logic [15:0] n, input logic o);
        dir_rows.push_back('{ROW_CHAR, ch, st, 1'b1, '{v, n, o}});
    endtask

    task automatic row_base(input logic [5:0] b);
        dir_rows.push_back('{ROW_BASE, itp_pkg::char_t'(b), 1'b0, 1'b0, '0});
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // The receiver stalls on a pattern of its own that it picks anew at random
    // intervals: no stall, random stall, a stall three times in four, or long
    // stretches held off.
    initial
    begin
        int mode;
        int tick;
        result_stall = 1'b0;
        tick = 0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(20, 80))
            begin
                @(negedge clk);
                case (mode)
                    0: result_stall <= 1'b0;
                    1: result_stall <= 1'($urandom_range(0, 1));
                    2: result_stall <= (tick % 4) != 0;
                    default: result_stall <= (tick % 32) < 20;
                endcase
                tick++;
            end
        end
    end

    // Each accepted result is held against the oldest one owed. Outputs are
    // read just after the rising edge, before the block's registers move.
    always @(posedge clk)
    begin
        parse_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (result_q.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("unexpected result: value %h count %0d ovf %b",
                             parsed_value, consumed_count, overflow_flag);
            end
            else
            begin
                want = result_q.pop_front();
                if (parsed_value !== want.value || consumed_count !== want.count
                    || overflow_flag !== want.ovf)
                begin
                    errors++;
                    if (errors <= REPORT_MAX)
                        $display("mismatch exp %h %0d %b got %h %0d %b",
                                 want.value, want.count, want.ovf,
                                 parsed_value, consumed_count, overflow_flag);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        int base_list[9];
        int phase_idx;
        int target;
        stim_row_t row;

        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        base_select  = itp_pkg::BASE_DEC;
        char_valid   = 1'b0;
        char_code    = CHR_NUL;
        string_start = 1'b0;
        errors       = 0;
        cycle_count  = 0;
        burst_left   = 0;
        live_chars   = 0;
        pending_start = 1'b0;
        base_reg     = itp_pkg::BASE_DEC;
        clear_parse();

        // Directed table. After reset the base is decimal, and a character
        // before any string start must be ignored.
        row_char("5", 1'b0);
        row_char("7", 1'b1);
        row_check(CHR_NUL, 1'b0, 64'd7, 16'd1, 1'b0);
        // Blanks and a minus sign, ended by a letter outside base ten.
        row_char(itp_pkg::CH_SPACE, 1'b1);
        row_char(itp_pkg::CH_TAB, 1'b0);
        row_char(itp_pkg::CH_MINUS, 1'b0);
        row_char("4", 1'b0);
        row_char("2", 1'b0);
        row_char(itp_pkg::CH_LO_X, 1'b0);
        // A restart drops the open parse; a sign with no digits still
        // counts, and a character after the end is ignored.
        row_char("1", 1'b1);
        row_char(itp_pkg::CH_PLUS, 1'b1);
        row_check(".", 1'b0, 64'd0, 16'd1, 1'b0);
        row_char("3", 1'b0);
        // Automatic base: a hex prefix with no hex digit after it.
        row_base(itp_pkg::BASE_AUTO);
        row_char(itp_pkg::CH_0, 1'b1);
        row_char(itp_pkg::CH_LO_X, 1'b0);
        row_check("g", 1'b0, 64'd0, 16'd2, 1'b0);
        row_char(itp_pkg::CH_MINUS, 1'b1);
        row_char(itp_pkg::CH_0, 1'b0);
        row_char(itp_pkg::CH_UP_X, 1'b0);
        row_char("f", 1'b0);
        row_char("F", 1'b0);
        row_char(8'hFF, 1'b0);
        // Octal prefix ended by a digit that octal does not have.
        row_char(itp_pkg::CH_0, 1'b1);
        row_check("8", 1'b0, 64'd0, 16'd1, 1'b0);
        // Largest regular base, then base one, which rejects every non-zero.
        row_base(6'd36);
        row_char(itp_pkg::CH_LO_Z, 1'b1);
        row_char(itp_pkg::CH_UP_Z, 1'b0);
        row_char(CHR_NUL, 1'b0);
        row_base(6'd1);
        row_check("1", 1'b1, 64'd0, 16'd0, 1'b0);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.kind == ROW_BASE)
                write_base(row.ch[5:0]);
            else
                send_char(row.ch, row.st, row.given, row.result);
        end

        // Random part: each phase sets a base, the extremes and the
        // unusual ones first, then random ones, and sends a few strings.
        base_list = '{0, 1, 2, 8, 10, 16, 36, 37, 63};
        phase_idx = 0;
        target = live_chars + RANDOM_CHARS;
        while (live_chars < target)
        begin
            if (phase_idx < 9)
                write_base(6'(base_list[phase_idx]));
            else
                write_base(6'($urandom_range(0, 63)));
            phase_idx++;
            repeat ($urandom_range(4, 10)) send_string();
        end

        char_valid <= 1'b0;
        while (result_q.size() != 0)
            @(negedge clk);
        repeat (END_DRAIN) @(posedge clk);

        if (errors == 0 && result_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
